>>> hdl/fpas_pkg.sv
package fpas_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned MAN_W  = 23;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hFF;

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_INVALID  = 2'd1;
    localparam t_status STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] sum_word;
        t_status           status;
    } t_out_word;

    // leading zero count of a 32 bit value, 32 for zero
    function automatic logic [5:0] lzc32(input logic [WORD_W-1:0] v);
        logic [5:0] cnt;
        cnt = 6'd32;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                cnt = 6'(WORD_W - 1 - i);
            end
        end
        return cnt;
    endfunction

endpackage

>>> hdl/fpas_in_if.sv
interface fpas_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] operand_a;
    logic [31:0] operand_b;

    modport source (output valid, output action, output operand_a, output operand_b,
                    input ready);
    modport sink (input valid, input action, input operand_a, input operand_b,
                  output ready);
endinterface

>>> hdl/fpas_out_if.sv
interface fpas_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sum_word;
    logic [1:0]  status;

    modport source (output valid, output sum_word, output status, input ready);
    modport sink (input valid, input sum_word, input status, output ready);
endinterface

>>> hdl/fpas_core.sv
module fpas_core (
    input  fpas_pkg::t_in_word  i_word,
    output fpas_pkg::t_out_word o_word
);
    import fpas_pkg::*;

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [31:0] y;
    logic        swap;
    logic        same_sign;
    logic        equal_mag;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [23:0] mx;
    logic [23:0] my;
    logic [7:0]  align_sh;
    logic        far;
    logic [31:0] my_add;
    logic [31:0] my_sub;
    logic [31:0] v;
    logic [8:0]  lim;
    logic [5:0]  clz;
    logic [8:0]  n;
    logic [8:0]  eo;
    logic [31:0] w;
    logic [31:0] m;
    logic [31:0] word;

    always_comb begin
        a = i_word.operand_a;
        b = {i_word.operand_b[31] ^ i_word.action, i_word.operand_b[30:0]};
        same_sign = (a[31] == b[31]);
        equal_mag = (a[30:0] == b[30:0]);
        swap = (b[30:0] > a[30:0]);
        x = swap ? b : a;
        y = swap ? a : b;

        // denormals act as exponent one without the hidden bit
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};

        align_sh = ex - ey;
        far = (align_sh[7:5] != 3'd0);
        my_add = far ? 32'd0 : ({8'd0, my} >> align_sh[4:0]);
        my_sub = far ? 32'd0 : ({my, 8'd0} >> align_sh[4:0]);

        if (same_sign) begin
            v = {8'd0, mx} + my_add;
            lim = {1'b0, ex} + 9'd8;
        end else begin
            v = {mx, 8'd0} - my_sub;
            lim = {1'b0, ex};
        end

        // normalize, limited by the exponent
        clz = lzc32(v);
        n = ((v == 32'd0) || (lim < {3'd0, clz})) ? lim : {3'd0, clz};
        eo = lim - n;
        w = (eo != 9'd0) ? {v[30:0], 1'b0} : v;
        m = (n[8:5] != 4'd0) ? 32'd0 : (w << n[4:0]);
        word = {x[31], eo[7:0], m[31:9]};

        if (!same_sign && equal_mag) begin
            word = 32'd0;
        end

        if ((a[30:23] == EXP_ALL_ONES) || (b[30:23] == EXP_ALL_ONES)) begin
            o_word.sum_word = 32'd0;
            o_word.status   = STATUS_INVALID;
        end else if (word[30:23] == EXP_ALL_ONES) begin
            o_word.sum_word = 32'd0;
            o_word.status   = STATUS_OVERFLOW;
        end else begin
            o_word.sum_word = word;
            o_word.status   = STATUS_OK;
        end
    end

endmodule

>>> hdl/float32_add_subtract_truncating.sv
// Single precision add / subtract, truncating, no rounding.
// Input channel i_in carries action (0 add, 1 subtract operand_b from
// operand_a) and two IEEE single precision words; output channel o_out
// carries sum_word and status (0 ok, 1 NaN or infinity operand,
// 2 result overflow; sum_word is zero whenever status is not ok).
// Both channels use valid / ready; a word moves on a clock edge where
// both are high.
// An accepted word passes through the input register, then the result
// register, which drives the output channel.
// Throughput: one word per cycle while the receiver keeps taking results;
// the input register and the result register each hold one word, so a new
// word is accepted while a finished result waits to be taken.
// When the receiver stalls, the result register holds its word and the
// input register fills; ready drops only once both are full.
// Reset (synchronous, i_rst_n low) empties both registers; no results
// are pending afterwards.
module float32_add_subtract_truncating (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fpas_in_if.sink            i_in,
    fpas_out_if.source         o_out
);
    import fpas_pkg::*;

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_s2_valid;
    t_out_word r_s2_word;
    t_in_word  n_s1_word;
    t_out_word n_s2_word;
    logic      s2_free;
    logic      s1_free;

    assign s2_free = !r_s2_valid || o_out.ready;
    assign s1_free = !r_s1_valid || s2_free;

    assign i_in.ready = s1_free;

    assign n_s1_word = '{action: i_in.action, operand_a: i_in.operand_a,
                         operand_b: i_in.operand_b};

    fpas_core u_core (
        .i_word (r_s1_word),
        .o_word (n_s2_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1_word <= n_s1_word;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_word <= n_s2_word;
        end
    end

    assign o_out.valid    = r_s2_valid;
    assign o_out.sum_word = r_s2_word.sum_word;
    assign o_out.status   = r_s2_word.status;

endmodule

>>> hdl/fpas_checker.sv
module fpas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_sum_word,
    input logic [1:0]  i_status
);
    import fpas_pkg::*;

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // error status always comes with a zero word
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != STATUS_OK) |-> (i_sum_word == 32'd0))
        else $error("nonzero word with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == STATUS_OK) || (i_status == STATUS_INVALID)
                        || (i_status == STATUS_OVERFLOW))
        else $error("unknown status code");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sum_word)
                                        && $stable(i_status))
        else $error("stalled result changed");

endmodule

bind float32_add_subtract_truncating fpas_checker u_fpas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum_word  (o_out.sum_word),
    .i_status    (o_out.status)
);

>>> verif/float32_add_subtract_truncating_tb.sv
`timescale 1ns / 100ps

module float32_add_subtract_truncating_tb;
    import fpas_pkg::*;

    localparam int unsigned N_RANDOM   = 1300;
    localparam int unsigned STALL_MAX  = 2000;
    localparam int unsigned SETTLE_CYC = 8;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_SUB = 1'b1;

    typedef struct packed {
        logic        has_exp;
        logic [31:0] sum_word;
        t_status     status;
    } t_vector;

    logic i_clk;
    logic i_rst_n;

    fpas_in_if  in_ch ();
    fpas_out_if out_ch ();

    float32_add_subtract_truncating u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_out_word sum_queue[$];
    int        n_errors;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_recv;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] sh_l(input logic [31:0] v, input logic [31:0] s);
        return (s >= 32) ? 32'd0 : (v << s);
    endfunction

    function automatic logic [31:0] sh_r(input logic [31:0] v, input logic [31:0] s);
        return (s >= 32) ? 32'd0 : (v >> s);
    endfunction

    function automatic logic [31:0] clz_capped(input logic [31:0] v, input logic [31:0] cap);
        logic [31:0] n;
        n = 0;
        while (n < cap && n < 32 && (sh_l(v, n) & 32'h8000_0000) == 32'd0) n++;
        if (n == 32 && cap > 32) n = cap;
        return n;
    endfunction

    // magnitude add or subtract of same / opposite sign words
    function automatic logic [31:0] fp_combine(input logic [31:0] x_in, input logic [31:0] y_in,
                                               input bit same_sign);
        logic [31:0] x, y, ex, ey, mx, my, acc, n, eo;
        x = x_in;
        y = y_in;
        if (same_sign) begin
            if (y > x) begin x = y_in; y = x_in; end
        end else begin
            if (x[30:0] == y[30:0]) return 32'd0;
            if (y[30:0] > x[30:0]) begin x = y_in; y = x_in; end
        end
        ex = {24'd0, x[30:23]};
        ey = {24'd0, y[30:23]};
        mx = {9'd0, x[22:0]};
        my = {9'd0, y[22:0]};
        if (ex == 0) ex = 1; else mx[23] = 1'b1;
        if (ey == 0) ey = 1; else my[23] = 1'b1;
        if (same_sign) begin
            my  = sh_r(my, ex - ey);
            acc = mx + my;
            n   = clz_capped(acc, ex + 8);
            eo  = ex + 8 - n;
        end else begin
            mx  = mx << 8;
            my  = sh_r(my << 8, ex - ey);
            acc = mx - my;
            n   = clz_capped(acc, ex);
            eo  = ex - n;
        end
        if (eo != 0) acc = acc << 1;
        return {x[31], 31'd0} | {1'b0, eo[7:0], 23'd0} | (sh_l(acc, n) >> 9);
    endfunction

    function automatic t_out_word fp_add_sub(input logic act, input logic [31:0] a,
                                             input logic [31:0] b_in);
        t_out_word r;
        logic [31:0] b;
        b = b_in;
        r.status = STATUS_OK;
        if (a[30:23] == EXP_ALL_ONES || b[30:23] == EXP_ALL_ONES) begin
            r.sum_word = 32'd0;
            r.status   = STATUS_INVALID;
            return r;
        end
        if (act == ACT_SUB) b[31] = ~b[31];
        r.sum_word = fp_combine(a, b, a[31] == b[31]);
        if (r.sum_word[30:23] == EXP_ALL_ONES) begin
            r.sum_word = 32'd0;
            r.status   = STATUS_OVERFLOW;
        end
        return r;
    endfunction

    // directed stimulus; expected typed in where obvious
    t_in_word stim_vec[$];
    t_vector  want_vec[$];

    task automatic add_vec(input logic act, input logic [31:0] a, input logic [31:0] b,
                           input logic has, input logic [31:0] w, input t_status st);
        stim_vec.push_back('{act, a, b});
        want_vec.push_back('{has, w, st});
    endtask

    task automatic send_word(input t_in_word wd, input bit idle_ok);
        while (idle_ok && $urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= wd.action;
        in_ch.operand_a <= wd.operand_a;
        in_ch.operand_b <= wd.operand_b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sum_queue.push_back(fp_add_sub(wd.action, wd.operand_a, wd.operand_b));
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(7, 0))
            0: w[30:23] = 8'd0;
            1: w[30:23] = 8'hFF;
            2: w[30:23] = 8'(8'hFE - $urandom_range(2, 0));
            3: w[30:23] = 8'($urandom_range(40, 0));
            4: w[30:0]  = 31'd0;
            default: ;
        endcase
        return w;
    endfunction

    task automatic wait_drained();
        while (sum_queue.size() != 0) @(negedge i_clk);
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_recv) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // checker and watchdog
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_MAX) begin
                $display("[float32_add_subtract_truncating] ERROR");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (sum_queue.size() == 0) begin
                    $display("%0t unexpected word: sum %h status %0d", $time,
                             out_ch.sum_word, out_ch.status);
                    n_errors++;
                end else begin
                    exp_w = sum_queue.pop_front();
                    if (exp_w.sum_word !== out_ch.sum_word || exp_w.status !== out_ch.status) begin
                        $display("%0t mismatch: expected sum %h status %0d, got sum %h status %0d",
                                 $time, exp_w.sum_word, exp_w.status,
                                 out_ch.sum_word, out_ch.status);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        t_in_word wd;
        n_errors        = 0;
        idle_cycles     = 0;
        hold_recv       = 1'b0;
        send_idle_pct   = 31;
        recv_idle_pct   = 76;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready    = 1'b0;

        add_vec(ACT_ADD, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, STATUS_OK);
        add_vec(ACT_ADD, 32'h0000_0000, 32'h8000_0000, 1, 32'h0000_0000, STATUS_OK);
        add_vec(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, STATUS_OK);
        add_vec(ACT_SUB, 32'h8000_0000, 32'h0000_0000, 1, 32'h8000_0000, STATUS_OK);
        add_vec(ACT_SUB, 32'h3F80_0000, 32'h3F80_0000, 1, 32'h0000_0000, STATUS_OK);
        add_vec(ACT_ADD, 32'hC123_4567, 32'h4123_4567, 1, 32'h0000_0000, STATUS_OK);
        add_vec(ACT_ADD, 32'h7F80_0000, 32'h3F80_0000, 1, 32'h0000_0000, STATUS_INVALID);
        add_vec(ACT_SUB, 32'h3F80_0000, 32'hFFC0_0001, 1, 32'h0000_0000, STATUS_INVALID);
        add_vec(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0000, STATUS_INVALID);
        add_vec(ACT_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1, 32'h0000_0000, STATUS_OVERFLOW);
        add_vec(ACT_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1, 32'h0000_0000, STATUS_OVERFLOW);
        add_vec(ACT_ADD, 32'h3F80_0000, 32'h3F80_0000, 1, 32'h4000_0000, STATUS_OK);
        add_vec(ACT_ADD, 32'h0000_0001, 32'h0000_0001, 1, 32'h0000_0002, STATUS_OK);
        add_vec(ACT_SUB, 32'h0000_0001, 32'h0000_0002, 1, 32'h8000_0001, STATUS_OK);
        add_vec(ACT_ADD, 32'h007F_FFFF, 32'h0000_0001, 0, '0, STATUS_OK);
        add_vec(ACT_ADD, 32'h7F00_0000, 32'h0000_0001, 0, '0, STATUS_OK);
        add_vec(ACT_SUB, 32'h7F00_0000, 32'h0000_0001, 0, '0, STATUS_OK);
        add_vec(ACT_ADD, 32'h4B80_0000, 32'h3F80_0000, 0, '0, STATUS_OK);
        add_vec(ACT_SUB, 32'h3F80_0001, 32'h3F80_0000, 0, '0, STATUS_OK);
        add_vec(ACT_SUB, 32'h0080_0000, 32'h0000_0001, 0, '0, STATUS_OK);
        add_vec(ACT_ADD, 32'hBF7F_FFFF, 32'h8000_0001, 0, '0, STATUS_OK);
        add_vec(ACT_SUB, 32'h4120_0000, 32'hC0A0_0000, 0, '0, STATUS_OK);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows, typed expectation checked against the predictor too
        foreach (stim_vec[i]) begin
            if (want_vec[i].has_exp && fp_add_sub(stim_vec[i].action, stim_vec[i].operand_a,
                    stim_vec[i].operand_b) !== {want_vec[i].sum_word, want_vec[i].status}) begin
                $display("%0t mismatch: expected sum %h status %0d, predictor disagrees on row %0d",
                         $time, want_vec[i].sum_word, want_vec[i].status, i);
                n_errors++;
            end
            send_word(stim_vec[i], 1);
        end

        // receiver holds off while the sender keeps offering
        hold_recv = 1'b1;
        fork
            begin
                repeat (40) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            for (int k = 0; k < 6; k++) begin
                wd = '{1'($urandom_range(1, 0)), rand_float(), rand_float()};
                send_word(wd, 0);
            end
        join
        end_burst();
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 31 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                wd.action    = 1'($urandom_range(1, 0));
                wd.operand_a = rand_float();
                wd.operand_b = ($urandom_range(3, 0) == 0) ?
                               (wd.operand_a ^ ($urandom_range(1, 0) << 31) ^ $urandom_range(3, 0))
                               : rand_float();
                send_word(wd, 1);
                if (k % 20 == 0) begin
                    recv_idle_pct = (phase == 2) ? 0 : recv_idle_pct;
                end
            end
            end_burst();
            wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (n_errors == 0 && sum_queue.size() == 0) begin
            $display("[float32_add_subtract_truncating] OK");
        end else begin
            $display("[float32_add_subtract_truncating] ERROR");
        end
        $finish;
    end

endmodule

>>> float32_add_subtract_truncating.f
hdl/fpas_pkg.sv
hdl/fpas_in_if.sv
hdl/fpas_out_if.sv
hdl/fpas_core.sv
hdl/float32_add_subtract_truncating.sv
hdl/fpas_checker.sv
verif/float32_add_subtract_truncating_tb.sv
